// ----- src/atd_pkg.sv -----
// Shared types, constants and the generator step function for the archive table decryptor.
// Used by every module of the block but atd_ram; depends on nothing else.
package atd_pkg;

   localparam int unsigned WORD_W        = 32;
   localparam int unsigned TABLE_DEPTH   = 256;
   localparam int unsigned TABLE_AW      = 8;
   localparam int unsigned GEN_SEED_W    = 22;
   localparam int unsigned GEN_IDX_W     = 11;
   localparam int unsigned SEGMENT_OFFSET = 1024;

   localparam logic [WORD_W-1:0]     SEED_INIT     = 32'hEEEE_EEEE;
   localparam logic [WORD_W-1:0]     KEY_STIR      = 32'h1111_1111;
   localparam logic [WORD_W-1:0]     SEED_INC      = 32'd3;
   localparam logic [GEN_SEED_W-1:0] GEN_SEED_INIT = 22'h10_0001;
   localparam logic [GEN_SEED_W-1:0] GEN_MOD       = 22'h2A_AAAB;
   localparam logic [2:0]            GEN_LAST_ROW  = 3'd4;
   localparam logic [7:0]            GEN_LAST_COL  = 8'd255;
   localparam logic [GEN_IDX_W-1:0]  SEG_BASE      = GEN_IDX_W'(SEGMENT_OFFSET);

   typedef struct packed {
      logic                    we;
      logic [TABLE_AW-1:0]     addr;
      logic [WORD_W-1:0]       data;
      logic                    ready;
   } tbl_wr_type;

   // One step of s = (s * 125 + 3) mod 0x2AAAAB. Since 3 * 0x2AAAAB = 2^23 + 1,
   // 2^23 is congruent to -1, so the product folds into low part minus high part.
   function automatic logic [GEN_SEED_W-1:0] gen_step(input logic [GEN_SEED_W-1:0] s);
      logic [29:0] x;
      logic [22:0] lo;
      logic [6:0]  hi;
      logic [24:0] y;
      x  = {1'b0, s, 7'b0} - {7'b0, s, 1'b0} - {8'b0, s} + 30'd3;
      lo = x[22:0];
      hi = x[29:23];
      y  = {2'b0, lo} + {3'b0, GEN_MOD} - {18'b0, hi};
      if (y >= {2'b0, GEN_MOD, 1'b0}) begin
         y = y - {2'b0, GEN_MOD, 1'b0};
      end
      if (y >= {3'b0, GEN_MOD}) begin
         y = y - {3'b0, GEN_MOD};
      end
      return y[GEN_SEED_W-1:0];
   endfunction

endpackage

// ----- src/atd_ram.sv -----
// Generic RAM with one write port and two registered read ports.
// Depends on nothing else.
module atd_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_a_addr,
   output logic [WIDTH-1:0]         rd_a_data,
   input  logic [$clog2(DEPTH)-1:0] rd_b_addr,
   output logic [WIDTH-1:0]         rd_b_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem_ff[rd_a_addr];
      rd_b_ff <= mem_ff[rd_b_addr];
   end

   assign rd_a_data = rd_a_ff;
   assign rd_b_data = rd_b_ff;

endmodule

// ----- src/atd_keygen.sv -----
// Key table generator: runs the congruential sequence one step per cycle after reset.
// Depends on atd_pkg; drives the table write port of atd_cipher.
module atd_keygen (
   input  logic                clock,
   input  logic                reset,
   output atd_pkg::tbl_wr_type tbl
);

   logic [atd_pkg::GEN_SEED_W-1:0] gen_seed_ff, gen_seed_in;
   logic [7:0]                     gen_col_ff, gen_col_in;
   logic [2:0]                     gen_row_ff, gen_row_in;
   logic                           phase_ff, phase_in;
   logic [15:0]                    hi_ff, hi_in;
   logic                           done_ff, done_in;
   logic                           ready_ff, ready_in;
   logic [atd_pkg::GEN_SEED_W-1:0] seed_step;
   logic [atd_pkg::GEN_IDX_W-1:0]  idx;
   logic [atd_pkg::GEN_IDX_W-1:0]  rel;
   logic                           in_window;

   assign seed_step = atd_pkg::gen_step(gen_seed_ff);
   assign idx       = {gen_row_ff, gen_col_ff};
   assign rel       = idx - atd_pkg::SEG_BASE;
   assign in_window = (idx >= atd_pkg::SEG_BASE) &&
                      (rel < atd_pkg::GEN_IDX_W'(atd_pkg::TABLE_DEPTH));

   always_comb begin
      gen_seed_in = gen_seed_ff;
      gen_col_in  = gen_col_ff;
      gen_row_in  = gen_row_ff;
      phase_in    = phase_ff;
      hi_in       = hi_ff;
      done_in     = done_ff;
      ready_in    = done_ff;
      if (!done_ff) begin
         gen_seed_in = seed_step;
         phase_in    = !phase_ff;
         if (!phase_ff) begin
            hi_in = seed_step[15:0];
         end else if (gen_row_ff == atd_pkg::GEN_LAST_ROW) begin
            gen_row_in = '0;
            gen_col_in = gen_col_ff + 8'd1;
            done_in    = (gen_col_ff == atd_pkg::GEN_LAST_COL);
         end else begin
            gen_row_in = gen_row_ff + 3'd1;
         end
      end
      if (reset) begin
         gen_seed_in = atd_pkg::GEN_SEED_INIT;
         gen_col_in  = '0;
         gen_row_in  = '0;
         phase_in    = 1'b0;
         done_in     = 1'b0;
         ready_in    = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      gen_seed_ff <= gen_seed_in;
      gen_col_ff  <= gen_col_in;
      gen_row_ff  <= gen_row_in;
      phase_ff    <= phase_in;
      hi_ff       <= hi_in;
      done_ff     <= done_in;
      ready_ff    <= ready_in;
   end

   assign tbl.we    = !done_ff && phase_ff && in_window;
   assign tbl.addr  = rel[atd_pkg::TABLE_AW-1:0];
   assign tbl.data  = {hi_ff, seed_step[15:0]};
   assign tbl.ready = ready_ff;

endmodule

// ----- src/atd_cipher.sv -----
// Decryption datapath: key table RAM, running key and seed, output register and skid stage.
// Depends on atd_pkg and atd_ram; takes table writes from atd_keygen.
module atd_cipher (
   input  logic                       clock,
   input  logic                       reset,
   input  atd_pkg::tbl_wr_type        tbl,
   input  logic                       csr_valid,
   input  logic [atd_pkg::WORD_W-1:0] csr_wdata,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [atd_pkg::WORD_W-1:0] req_tdata,
   input  logic                       req_tuser,
   input  logic                       req_tlast,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [atd_pkg::WORD_W-1:0] rsp_tdata,
   output logic                       rsp_tlast
);

   logic [atd_pkg::WORD_W-1:0] start_key_ff, start_key_in;
   logic [atd_pkg::WORD_W-1:0] running_key_ff, running_key_in;
   logic [atd_pkg::WORD_W-1:0] running_seed_ff, running_seed_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [atd_pkg::WORD_W-1:0] rsp_data_ff, rsp_data_in;
   logic                       rsp_last_ff, rsp_last_in;
   logic                       skid_valid_ff, skid_valid_in;
   logic [atd_pkg::WORD_W-1:0] skid_data_ff, skid_data_in;
   logic                       skid_last_ff, skid_last_in;

   logic [atd_pkg::WORD_W-1:0] entry_run, entry_start, entry;
   logic [atd_pkg::WORD_W-1:0] key_cur, seed_cur, seed_mix, plain, key_nxt, seed_nxt;
   logic                       accept;

   // Port A follows the next running key, port B the next start key, so both
   // registered reads line up with the key registers.
   atd_ram #(
      .WIDTH (atd_pkg::WORD_W),
      .DEPTH (atd_pkg::TABLE_DEPTH)
   ) u_table (
      .clock     (clock),
      .wr_en     (tbl.we),
      .wr_addr   (tbl.addr),
      .wr_data   (tbl.data),
      .rd_a_addr (running_key_in[atd_pkg::TABLE_AW-1:0]),
      .rd_a_data (entry_run),
      .rd_b_addr (start_key_in[atd_pkg::TABLE_AW-1:0]),
      .rd_b_data (entry_start)
   );

   assign req_tready = tbl.ready && !skid_valid_ff;
   assign accept     = req_tvalid && req_tready;

   assign key_cur  = req_tuser ? start_key_ff : running_key_ff;
   assign seed_cur = req_tuser ? atd_pkg::SEED_INIT : running_seed_ff;
   assign entry    = req_tuser ? entry_start : entry_run;
   assign seed_mix = seed_cur + entry;
   assign plain    = req_tdata ^ (key_cur + seed_mix);
   assign key_nxt  = (((~key_cur) << 21) + atd_pkg::KEY_STIR) | (key_cur >> 11);
   assign seed_nxt = plain + seed_mix + (seed_mix << 5) + atd_pkg::SEED_INC;

   always_comb begin
      start_key_in    = csr_valid ? csr_wdata : start_key_ff;
      running_key_in  = accept ? key_nxt : running_key_ff;
      running_seed_in = accept ? seed_nxt : running_seed_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_data_in     = rsp_data_ff;
      rsp_last_in     = rsp_last_ff;
      skid_valid_in   = skid_valid_ff;
      skid_data_in    = skid_data_ff;
      skid_last_in    = skid_last_ff;
      if (!rsp_valid_ff || rsp_tready) begin
         if (skid_valid_ff) begin
            rsp_valid_in  = 1'b1;
            rsp_data_in   = skid_data_ff;
            rsp_last_in   = skid_last_ff;
            skid_valid_in = 1'b0;
         end else begin
            rsp_valid_in = accept;
            rsp_data_in  = plain;
            rsp_last_in  = req_tlast;
         end
      end else if (accept) begin
         skid_valid_in = 1'b1;
         skid_data_in  = plain;
         skid_last_in  = req_tlast;
      end
      if (reset) begin
         start_key_in    = '0;
         running_key_in  = '0;
         running_seed_in = atd_pkg::SEED_INIT;
         rsp_valid_in    = 1'b0;
         skid_valid_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      start_key_ff    <= start_key_in;
      running_key_ff  <= running_key_in;
      running_seed_ff <= running_seed_in;
      rsp_valid_ff    <= rsp_valid_in;
      rsp_data_ff     <= rsp_data_in;
      rsp_last_ff     <= rsp_last_in;
      skid_valid_ff   <= skid_valid_in;
      skid_data_ff    <= skid_data_in;
      skid_last_ff    <= skid_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ----- src/archive_table_decrypt_top.sv -----
// Top level of the archive table decryptor.
// Depends on atd_pkg, atd_keygen and atd_cipher.
//
//   channel  direction  handshake              payload
//   req      in         req_tvalid/req_tready  tdata cipher_word, tuser first_word,
//                                              tlast last_word
//   rsp      out        rsp_tvalid/rsp_tready  tdata plain_word, tlast end_of_table
//   csr      in         csr_valid/csr_ready    csr_wdata start_key
//
// One request is accepted per cycle while req_tready is high; its result is registered
// in the output register, or in the skid stage if the output stalls. The rate is set by
// the combinational key and seed update together with the registered key table read,
// which is addressed from the next key values. After reset the generator fills the key
// table, one sequence step per cycle; req_tready stays low until the fill is done.
// The skid stage lets one more request be taken before req_tready drops.
module archive_table_decrypt_top (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [atd_pkg::WORD_W-1:0] req_tdata,   // [31:0] cipher_word
   input  logic                       req_tuser,   // [0] first_word
   input  logic                       req_tlast,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [atd_pkg::WORD_W-1:0] rsp_tdata,   // [31:0] plain_word
   output logic                       rsp_tlast,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [atd_pkg::WORD_W-1:0] csr_wdata
);

   atd_pkg::tbl_wr_type tbl;

   assign csr_ready = 1'b1;

   atd_keygen u_keygen (
      .clock (clock),
      .reset (reset),
      .tbl   (tbl)
   );

   atd_cipher u_cipher (
      .clock      (clock),
      .reset      (reset),
      .tbl        (tbl),
      .csr_valid  (csr_valid && csr_ready),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ----- src/atd_checker.sv -----
// Port-level checks for archive_table_decrypt_top, attached by the bind below.
// Depends on atd_pkg.
module atd_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_tvalid,
   input logic                       req_tready,
   input logic                       rsp_tvalid,
   input logic                       rsp_tready,
   input logic [atd_pkg::WORD_W-1:0] rsp_tdata,
   input logic                       rsp_tlast
);

   // The key table is rebuilt after every reset, so no request can be taken right away.
   a_fill_after_reset: assert property (@(posedge clock)
      reset |=> !req_tready)
      else $error("request accepted before the key table was rebuilt");

   // A new result can only come from a request accepted in the cycle before.
   a_result_has_request: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready))
      else $error("result appeared without an accepted request");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled result changed or vanished");

   // With a stalled result and a request taken, the skid stage is full, so ready drops.
   a_skid_backpressure: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready && req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while both output stages were full");

endmodule

bind archive_table_decrypt_top atd_checker u_atd_checker (.*);

// ----- test/tb_archive_table_decrypt_top.sv -----
// Self-checking testbench for archive_table_decrypt_top: decrypts random and directed
// word streams under random stalls and compares each result with a built-in predictor.
// Depends on atd_pkg and the RTL of archive_table_decrypt_top.
module tb_archive_table_decrypt_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned CYCLE_LIMIT   = 200000;
   localparam int unsigned GEN_ENTRIES   = 1280;
   localparam int unsigned RANDOM_PHASES = 5;
   localparam int unsigned PHASE_WORDS   = 106;
   localparam logic [63:0] LCG_MODULUS   = 64'h2A_AAAB;
   localparam logic [63:0] LCG_FIRST     = 64'h10_0001;

   typedef struct packed {
      logic [atd_pkg::WORD_W-1:0] cipher;
      logic                       first;
      logic                       last;
   } cipher_word_type;

   typedef struct packed {
      logic [atd_pkg::WORD_W-1:0] plain;
      logic                       last;
   } plain_word_type;

   logic                       clock      = 1'b0;
   logic                       reset      = 1'b1;
   logic                       req_tvalid = 1'b0;
   logic                       req_tready;
   logic [atd_pkg::WORD_W-1:0] req_tdata  = '0;
   logic                       req_tuser  = 1'b0;
   logic                       req_tlast  = 1'b0;
   logic                       rsp_tvalid;
   logic                       rsp_tready = 1'b0;
   logic [atd_pkg::WORD_W-1:0] rsp_tdata;
   logic                       rsp_tlast;
   logic                       csr_valid  = 1'b0;
   logic                       csr_ready;
   logic [atd_pkg::WORD_W-1:0] csr_wdata  = '0;

   cipher_word_type            pending_words[$];
   plain_word_type             plain_expected[$];
   logic [atd_pkg::WORD_W-1:0] segment_keys[atd_pkg::TABLE_DEPTH];
   logic [atd_pkg::WORD_W-1:0] start_key_copy = '0;
   logic [atd_pkg::WORD_W-1:0] key_now        = '0;
   logic [atd_pkg::WORD_W-1:0] seed_now       = atd_pkg::SEED_INIT;
   logic                       req_took       = 1'b0;
   logic                       csr_took       = 1'b0;
   logic                       steady         = 1'b0;
   int unsigned                cycles         = 0;
   int unsigned                mismatches     = 0;
   int unsigned                words_taken    = 0;
   int unsigned                tables_started = 0;
   int unsigned                results_seen   = 0;
   int unsigned                key_settings   = 0;

   archive_table_decrypt_top u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata)
   );

   always #6ns clock = ~clock;

   function automatic plain_word_type decrypt_word(input cipher_word_type w);
      plain_word_type             r;
      logic [atd_pkg::WORD_W-1:0] k;
      logic [atd_pkg::WORD_W-1:0] s;
      logic [atd_pkg::WORD_W-1:0] p;
      if (w.first) begin
         key_now  = start_key_copy;
         seed_now = atd_pkg::SEED_INIT;
      end
      k        = key_now;
      s        = seed_now + segment_keys[k[7:0]];
      p        = w.cipher ^ (k + s);
      key_now  = ((~k << 21) + atd_pkg::KEY_STIR) | (k >> 11);
      seed_now = p + s + (s << 5) + atd_pkg::SEED_INC;
      r.plain  = p;
      r.last   = w.last;
      return r;
   endfunction

   task automatic queue_word(input logic [atd_pkg::WORD_W-1:0] cipher, input logic first,
                             input logic last);
      cipher_word_type w;
      w.cipher = cipher;
      w.first  = first;
      w.last   = last;
      pending_words.push_back(w);
   endtask

   // Mostly well-formed tables of random length, with some loose words whose
   // first and last flags are random.
   task automatic queue_random_words(input int unsigned count);
      int unsigned left;
      int unsigned run;
      bit          framed;
      left = count;
      while (left > 0) begin
         framed = ($urandom_range(0, 99) < 85);
         run    = framed ? $urandom_range(1, 32) : $urandom_range(1, 6);
         if (run > left) begin
            run = left;
         end
         for (int unsigned k = 0; k < run; k++) begin
            if (framed) begin
               queue_word($urandom(), k == 0, k == run - 1);
            end else begin
               queue_word($urandom(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end
         end
         left -= run;
      end
   endtask

   // The check runs after each rising edge has settled, so a word that the driver
   // has just taken from the queue is always seen on req_tvalid.
   task automatic wait_drained();
      do begin
         @(posedge clock);
         #1ns;
      end while (pending_words.size() != 0 || req_tvalid || plain_expected.size() != 0);
      repeat (4) @(negedge clock);
      @(posedge clock);
   endtask

   task automatic write_start_key(input logic [atd_pkg::WORD_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_wdata <= value;
      do @(negedge clock); while (!csr_took);
      csr_valid <= 1'b0;
      key_settings++;
      @(posedge clock);
   endtask

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d requests pending, %0d results outstanding",
                  cycles, pending_words.size(), plain_expected.size());
         $display("FAIL archive_table_decrypt_top");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp_tready <= steady || ($urandom_range(0, 99) >= 33);
   end

   always @(negedge clock) begin
      cipher_word_type w;
      if (!req_tvalid || req_took) begin
         if (pending_words.size() != 0 && (steady || $urandom_range(0, 99) >= 33)) begin
            w = pending_words.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= w.cipher;
            req_tuser  <= w.first;
            req_tlast  <= w.last;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      cipher_word_type w;
      plain_word_type  got;
      plain_word_type  want;
      req_took <= req_tvalid && req_tready;
      csr_took <= csr_valid && csr_ready;
      if (!reset && csr_valid && csr_ready) begin
         start_key_copy = csr_wdata;
      end
      if (!reset && req_tvalid && req_tready) begin
         w.cipher = req_tdata;
         w.first  = req_tuser;
         w.last   = req_tlast;
         plain_expected.push_back(decrypt_word(w));
         words_taken++;
         if (req_tuser) begin
            tables_started++;
         end
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.plain = rsp_tdata;
         got.last  = rsp_tlast;
         results_seen++;
         if (plain_expected.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("Unexpected result: plain_word %h end_of_table %b", got.plain,
                        got.last);
            end
         end else begin
            want = plain_expected.pop_front();
            if (got.plain !== want.plain || got.last !== want.last) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display({"Mismatch on result %0d: expected plain_word %h ",
                            "end_of_table %b, got %h %b"},
                           results_seen, want.plain, want.last, got.plain, got.last);
               end
            end
         end
      end
   end

   initial begin
      logic [63:0]                lcg;
      logic [15:0]                upper;
      int unsigned                idx;
      logic [atd_pkg::WORD_W-1:0] phase_keys[RANDOM_PHASES];

      // The generator emits entries column by column; only the last segment is kept.
      lcg = LCG_FIRST;
      for (int unsigned n = 0; n < GEN_ENTRIES; n++) begin
         lcg   = (lcg * 125 + 3) % LCG_MODULUS;
         upper = lcg[15:0];
         lcg   = (lcg * 125 + 3) % LCG_MODULUS;
         idx   = n / 5 + 256 * (n % 5);
         if (idx >= atd_pkg::SEGMENT_OFFSET &&
             idx < atd_pkg::SEGMENT_OFFSET + atd_pkg::TABLE_DEPTH) begin
            segment_keys[idx - atd_pkg::SEGMENT_OFFSET] = {upper, lcg[15:0]};
         end
      end

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // These requests wait out the table fill and use the reset key and seed.
      queue_word(32'h0000_0000, 1'b0, 1'b0);
      queue_word(32'hFFFF_FFFF, 1'b0, 1'b0);
      queue_word(32'h8000_0000, 1'b0, 1'b1);
      queue_word(32'h0000_0001, 1'b0, 1'b0);
      queue_word(32'h1234_5678, 1'b1, 1'b1);
      wait_drained();

      write_start_key(32'hFFFF_FFFF);
      queue_word(32'hFFFF_FFFF, 1'b1, 1'b0);
      queue_word(32'h0000_0000, 1'b0, 1'b0);
      queue_word(32'h5555_5555, 1'b0, 1'b0);
      queue_word(32'hAAAA_AAAA, 1'b0, 1'b1);
      queue_word(32'h0000_0000, 1'b1, 1'b1);
      queue_word(32'hFFFF_FFFF, 1'b0, 1'b0);
      wait_drained();

      write_start_key(32'h0000_0000);
      queue_word(32'hFFFF_FFFF, 1'b1, 1'b0);
      queue_word(32'h0000_0001, 1'b1, 1'b0);
      queue_word(32'h8000_0000, 1'b0, 1'b1);
      wait_drained();

      write_start_key(32'h8000_00FF);
      queue_word(32'h7FFF_FFFF, 1'b1, 1'b0);
      queue_word(32'hDEAD_BEEF, 1'b0, 1'b0);
      queue_word(32'h0F0F_F0F0, 1'b0, 1'b1);
      queue_word(32'h0000_0000, 1'b1, 1'b0);
      queue_word(32'hFFFF_FFFF, 1'b0, 1'b1);
      wait_drained();

      phase_keys[0] = $urandom();
      phase_keys[1] = 32'hFFFF_FFFF;
      phase_keys[2] = $urandom();
      phase_keys[3] = 32'h0000_0000;
      phase_keys[4] = $urandom();
      for (int unsigned ph = 0; ph < RANDOM_PHASES; ph++) begin
         write_start_key(phase_keys[ph]);
         steady = (ph == 2);
         queue_random_words(PHASE_WORDS);
         wait_drained();
      end
      steady = 1'b0;

      repeat (8) @(posedge clock);
      $display("Decrypted %0d requests in %0d tables over %0d start keys, %0d results checked.",
               words_taken, tables_started, key_settings, results_seen);
      $display("Mismatches: %0d", mismatches);
      if (mismatches == 0 && plain_expected.size() == 0) begin
         $display("PASS archive_table_decrypt_top");
      end else begin
         $display("FAIL archive_table_decrypt_top");
      end
      $finish;
   end

endmodule

// ----- archive_table_decrypt_top.f -----
src/atd_pkg.sv
src/atd_ram.sv
src/atd_keygen.sv
src/atd_cipher.sv
src/archive_table_decrypt_top.sv
src/atd_checker.sv
test/tb_archive_table_decrypt_top.sv
